// File: hw/rtl/assert_macros.svh
// assertion macros used by perlin_noise_2d_octaves
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/pn2o_pkg.sv
// package for the 2d octave perlin noise block
// types, constants and gradient rom; no dependencies
`default_nettype none
package pn2o_pkg;
  localparam int MaxOctaves = 8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_HASH1, ST_HASH2, ST_DOT, ST_LERP, ST_DIV, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    CFG_OCTAVES = 3'd0, CFG_AMP = 3'd1, CFG_FREQ = 3'd2, CFG_PERSIST = 3'd3,
    CFG_LACUN = 3'd4
  } cfg_idx_t;

  // cosine of 2*pi*k/32 in Q1.14
  function automatic logic signed [15:0] grad_cos(input logic [4:0] k);
    logic [15:0] qc [0:8];
    logic [2:0] r;
    logic [3:0] ri;
    logic signed [15:0] v;
    qc[0] = 16'd16384; qc[1] = 16'd16069; qc[2] = 16'd15137; qc[3] = 16'd13623;
    qc[4] = 16'd11585; qc[5] = 16'd9102;  qc[6] = 16'd6270;  qc[7] = 16'd3196;
    qc[8] = 16'd0;
    r = k[2:0];
    ri = 4'd8 - {1'b0, r};
    unique case (k[4:3])
      2'd0: v = $signed(qc[{1'b0, r}]);
      2'd1: v = -$signed(qc[ri]);
      2'd2: v = -$signed(qc[{1'b0, r}]);
      default: v = $signed(qc[ri]);
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/pn2o_fade.sv
// quintic fade of a Q0.16 fraction, three registered multiply stages
// depends on pn2o_pkg
`default_nettype none
module pn2o_fade import pn2o_pkg::*; (
  input  wire logic        clk,
  input  wire logic [15:0] t,
  output logic      [16:0] fade
);
  logic [15:0] t_d;
  logic [31:0] t2;
  logic signed [35:0] u;
  logic [31:0] t3;
  logic signed [20:0] u2;
  logic signed [37:0] uv;
  logic signed [55:0] f;

  // stage 1: t*t and t*(6t-15)
  always_comb begin
    uv = $signed({22'd0, t}) * ($signed({20'd0, t, 2'b0} + {21'd0, t, 1'b0})
         - 38'sd983040);
  end
  always_ff @(posedge clk) begin
    t_d <= t;
    t2 <= {16'd0, t} * {16'd0, t};
    u <= 36'(uv >>> 16);
  end
  // stage 2: t3 and t*(6t-15)+10
  always_ff @(posedge clk) begin
    t3 <= ({16'd0, t2[31:16]} * {16'd0, t_d}) >> 16;
    u2 <= 21'(u + 36'sd655360);
  end
  // stage 3: product and clamp
  always_comb f = $signed({24'd0, t3}) * $signed({{35{u2[20]}}, u2});
  always_ff @(posedge clk) begin
    if (f < 0) fade <= 17'd0;
    else if ((f >>> 16) > 56'sd65536) fade <= 17'd65536;
    else fade <= 17'(f >>> 16);
  end
endmodule
`default_nettype wire

// File: hw/rtl/perlin_noise_2d_octaves.sv
// 2d fractal perlin noise; permutation table memory, octave sequencer, divider
// depends on pn2o_pkg, pn2o_fade and assert_macros.svh
// A load item (mode 0) writes one permutation entry. A sample item runs each
// octave through one setup step, two inner reads and four corner hash reads of
// the single-port permutation memory, four dot products and three lerp steps,
// then a 48-step restoring divide. The input stalls until the result is loaded
// into the output register; new items are taken while it waits there, and a
// finished sample holds until it drains.
`default_nettype none
`include "assert_macros.svh"
module perlin_noise_2d_octaves import pn2o_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid_in,
  output logic             stall_in,
  input  wire logic        mode,
  input  wire logic [7:0]  table_index,
  input  wire logic [7:0]  table_value,
  input  wire logic signed [31:0] x_coord,
  input  wire logic signed [31:0] z_coord,
  output logic             valid_out,
  input  wire logic        stall_out,
  output logic signed [15:0] noise_value,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  logic [3:0]  octave_count;
  logic [15:0] base_amplitude, persistence, lacunarity;
  logic [23:0] base_frequency;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 4'd1; base_amplitude <= 16'd256;
      base_frequency <= 24'd65536; persistence <= 16'd32768; lacunarity <= 16'd8192;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OCTAVES: octave_count <= cfg_data[3:0];
        CFG_AMP:     base_amplitude <= cfg_data[15:0];
        CFG_FREQ:    base_frequency <= cfg_data;
        CFG_PERSIST: persistence <= cfg_data[15:0];
        CFG_LACUN:   lacunarity <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic [3:0] phase;
  logic [3:0] oct, n_oct;
  logic signed [31:0] xs, zs;
  logic [15:0] amp;
  logic [23:0] freq;
  logic [7:0] cx, cz;
  logic [15:0] fx, fz;
  logic [7:0] inner [0:1];
  logic [4:0] gk [0:3];
  logic signed [47:0] sum;
  logic [19:0] total;
  logic [5:0] dcnt;
  logic [47:0] rem_q, quo;
  logic res_neg;

  // permutation memory, one port, registered read
  logic [7:0] perm [0:255];
  logic [7:0] mem_addr, mem_rd;
  logic mem_we;
  always_ff @(posedge clk) begin
    if (mem_we) perm[mem_addr] <= table_value;
    mem_rd <= perm[mem_addr];
  end

  logic accept_in, out_load;
  assign stall_in = (state != ST_IDLE);
  assign accept_in = valid_in && !stall_in;
  // result register free or draining this cycle
  assign out_load = (state == ST_OUT) && (!valid_out || !stall_out);

  // scaled coordinates
  logic signed [63:0] px, pz;
  always_comb begin
    px = 64'(xs) * $signed({40'd0, freq});
    pz = 64'(zs) * $signed({40'd0, freq});
  end

  // memory address sequencing, inner reads in hash1, corner hashes in hash2
  always_comb begin
    mem_we = accept_in && !mode;
    mem_addr = table_index;
    if (state == ST_HASH1) mem_addr = phase[0] ? cx + 8'd1 : cx;
    else if (state == ST_HASH2) begin
      unique case (phase[1:0])
        2'd0: mem_addr = inner[0] + cz;
        2'd1: mem_addr = inner[1] + cz;
        2'd2: mem_addr = inner[0] + cz + 8'd1;
        default: mem_addr = inner[1] + cz + 8'd1;
      endcase
    end
  end

  // fade units
  logic [16:0] ux, uz;
  pn2o_fade u_fx (.clk(clk), .t(fx), .fade(ux));
  pn2o_fade u_fz (.clk(clk), .t(fz), .fade(uz));

  // dot products and lerp, one corner term per cycle
  logic signed [17:0] dxo, dzo;
  logic signed [35:0] dot [0:3];
  logic signed [36:0] e0, e1;
  logic [1:0] ci;
  always_comb begin
    ci = phase[1:0];
    dxo = ci[0] ? $signed({2'b0, fx}) - 18'sd65536 : $signed({2'b0, fx});
    dzo = ci[1] ? $signed({2'b0, fz}) - 18'sd65536 : $signed({2'b0, fz});
  end
  logic signed [35:0] dcur;
  always_comb dcur = 36'(grad_cos(gk[ci]) * dxo) + 36'(grad_cos(gk[ci] + 5'd24) * dzo);

  function automatic logic signed [36:0] lerp(input logic signed [36:0] a,
      input logic signed [36:0] b, input logic [16:0] t);
    logic signed [55:0] m;
    m = 56'(b - a) * $signed({39'd0, t});
    return a + 37'(m >>> 16);
  endfunction

  logic signed [17:0] oval;
  logic signed [36:0] eres;
  assign eres = lerp(e0, e1, uz);

  // next frequency before saturation
  logic [39:0] nfreq;
  always_comb nfreq = ({16'd0, freq} * {24'd0, lacunarity}) >> 12;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept_in && mode) state_next = ST_SETUP;
      ST_SETUP: state_next = (oct == n_oct) ? ST_DIV : ST_HASH1;
      ST_HASH1: if (phase == 4'd1) state_next = ST_HASH2;
      ST_HASH2: if (phase == 4'd4) state_next = ST_DOT;
      ST_DOT:   if (phase == 4'd3) state_next = ST_LERP;
      ST_LERP:  if (phase == 4'd2) state_next = ST_SETUP;
      ST_DIV:   if (dcnt == 6'd48) state_next = ST_OUT;
      ST_OUT:   if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; phase <= '0; valid_out <= 1'b0;
    end else begin
      if (state_next != state) phase <= '0; else phase <= phase + 4'd1;
      state <= state_next;
      if (out_load) valid_out <= 1'b1;
      else if (valid_out && !stall_out) valid_out <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        xs <= x_coord; zs <= z_coord; amp <= base_amplitude;
        freq <= base_frequency; oct <= '0; sum <= '0; total <= '0;
        n_oct <= (octave_count > 4'(MaxOctaves)) ? 4'(MaxOctaves) : octave_count;
      end
      ST_SETUP: begin
        cx <= px[39:32]; cz <= pz[39:32];
        fx <= px[31:16]; fz <= pz[31:16];
        dcnt <= '0;
        res_neg <= sum < 0;
        rem_q <= '0;
        quo <= sum < 0 ? 48'(-sum) : 48'(sum);
      end
      ST_HASH1: begin
        if (phase == 4'd1) inner[0] <= mem_rd;
      end
      ST_HASH2: begin
        if (phase == 4'd0) inner[1] <= mem_rd;
        else gk[2'(phase - 4'd1)] <= mem_rd[4:0];
      end
      ST_DOT: begin
        dot[ci] <= dcur;
      end
      ST_LERP: begin
        if (phase == 4'd0) begin
          e0 <= lerp(37'(dot[0]), 37'(dot[1]), ux);
          e1 <= lerp(37'(dot[2]), 37'(dot[3]), ux);
        end
        if (phase == 4'd1) oval <= 18'(eres >>> 15);
        if (phase == 4'd2) begin
          sum <= sum + 48'(oval * $signed({1'b0, amp}));
          total <= total + 20'(amp);
          amp <= 16'(({16'd0, amp} * {16'd0, persistence}) >> 16);
          freq <= (nfreq > 40'd16777215) ? 24'hFFFFFF : nfreq[23:0];
          oct <= oct + 4'd1;
        end
      end
      ST_DIV: begin
        if (dcnt < 6'd48) begin
          if ({rem_q[46:0], quo[47]} >= {28'd0, total}) begin
            rem_q <= {rem_q[46:0], quo[47]} - {28'd0, total};
            quo <= {quo[46:0], 1'b1};
          end else begin
            rem_q <= {rem_q[46:0], quo[47]};
            quo <= {quo[46:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          if (total == 0) noise_value <= '0;
          else if (res_neg) noise_value <= (quo > 48'd32768) ? 16'sh8000 : 16'(-quo);
          else noise_value <= (quo > 48'd32767) ? 16'sh7FFF : quo[15:0];
        end
      end
      default: ;
    endcase
  end

  `CHK_IMPL(a_no_accept_busy, state != ST_IDLE, stall_in, "input taken while busy")
  `CHK_NEXT(a_out_after_div, state == ST_OUT, valid_out, "result not shown")
  `CHK_IMPL(a_oct_bound, state == ST_SETUP, oct <= n_oct, "octave count overrun")
endmodule
`default_nettype wire
